>>> rtl/core/rgmg_pkg.sv
// Package for the rectangular geofence motion gate.
// Transaction structs, register map, motion and zone codes, heading constants.
// No dependencies.
`default_nettype none

package rgmg_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned MarginW  = 23;
  localparam int unsigned HeadingW = 12;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [HeadingW-1:0] HEADING_0    = 12'd0;
  localparam logic [HeadingW-1:0] HEADING_90   = 12'd900;
  localparam logic [HeadingW-1:0] HEADING_180  = 12'd1800;
  localparam logic [HeadingW-1:0] HEADING_270  = 12'd2700;
  localparam logic [HeadingW-1:0] HEADING_FULL = 12'd3600;

  localparam logic [TimeW-1:0] TIMEOUT_RESET = 32'd500;

  typedef enum logic [2:0] {
    REG_MIN_X       = 3'd0,
    REG_MIN_Y       = 3'd1,
    REG_MAX_X       = 3'd2,
    REG_MAX_Y       = 3'd3,
    REG_EDGE_MARGIN = 3'd4,
    REG_TIMEOUT     = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    MOT_STOP     = 3'd0,
    MOT_FORWARD  = 3'd1,
    MOT_BACKWARD = 3'd2,
    MOT_LEFT     = 3'd3,
    MOT_RIGHT    = 3'd4
  } motion_t;

  typedef enum logic [2:0] {
    ZONE_DISABLED = 3'd0,
    ZONE_UNKNOWN  = 3'd1,
    ZONE_STALE    = 3'd2,
    ZONE_OUTSIDE  = 3'd3,
    ZONE_NEAR     = 3'd4,
    ZONE_SAFE     = 3'd5
  } zone_t;

  typedef struct packed {
    logic                       cmd;
    logic signed [CoordW-1:0]   pos_x;
    logic signed [CoordW-1:0]   pos_y;
    logic        [HeadingW-1:0] heading_tenths;
    logic        [2:0]          motion;
    logic        [TimeW-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic       motion_allowed;
    logic       emergency_stop;
    logic [2:0] zone_status;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/rectangular_geofence_motion_gate.sv
// Top level of the rectangular geofence motion gate.
// Input register, single-pass evaluation, result register, APB register file.
// Depends on rgmg_pkg.
//
//   channel | ports                          | payload
//   input   | in_valid / in_ready            | rgmg_pkg::in_item_t
//   result  | out_valid / out_ready          | rgmg_pkg::out_item_t
//   config  | cfg_psel/penable/pwrite/pready | cfg_paddr, cfg_pwdata, cfg_prdata
//
// One transaction per cycle sustained while out_ready holds high; after input accept
// the result passes through the input register, then the result register.
// The stored position updates when a position-update (cmd) transaction moves into the result register.
// A stalled result holds; the input register keeps taking transactions while
// the result register frees in the same cycle.
// rst_n is synchronous, active low; the timeout register resets to 500.
`default_nettype none

module rectangular_geofence_motion_gate (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire rgmg_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rgmg_pkg::out_item_t               out_data,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [rgmg_pkg::AddrW-1:0]   cfg_paddr,
  input  wire logic [rgmg_pkg::DataW-1:0]   cfg_pwdata,
  output logic [rgmg_pkg::DataW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned CW = rgmg_pkg::CoordW;
  localparam int unsigned EW = rgmg_pkg::CoordW + 2;

  logic signed [CW-1:0]                  min_x_r, min_y_r, max_x_r, max_y_r;
  logic [rgmg_pkg::MarginW-1:0]          margin_r;
  logic [rgmg_pkg::TimeW-1:0]            timeout_r;

  logic signed [CW-1:0]                  cur_x_r, cur_y_r;
  logic [rgmg_pkg::HeadingW-1:0]         cur_head_r;
  logic [rgmg_pkg::TimeW-1:0]            stamp_r;
  logic                                  pos_valid_r;

  logic                                  s1_valid_r;
  rgmg_pkg::in_item_t                    s1_r;
  logic                                  out_valid_r;
  rgmg_pkg::out_item_t                   out_r;

  logic                                  s1_adv;
  logic                                  cfg_wr;
  logic                                  cfg_bound_wr;
  rgmg_pkg::reg_idx_t                    cfg_idx;

  logic signed [CW-1:0]                  eff_x, eff_y;
  logic [rgmg_pkg::HeadingW-1:0]         head_raw, head;
  logic [rgmg_pkg::TimeW-1:0]            eff_stamp, age;
  logic                                  eff_pv;
  logic                                  en, fresh, outside, near;
  logic signed [EW-1:0]                  x_e, y_e, lo_x, hi_x, lo_y, hi_y;
  logic                                  c_dxp, c_dxn, c_dyp, c_dyn;
  logic                                  dxp, dxn, dyp, dyn;
  logic                                  x_lo, x_hi, y_lo, y_hi;
  logic                                  n_xlo, n_xhi, n_ylo, n_yhi;
  logic                                  dir_ok;
  rgmg_pkg::out_item_t                   res_nxt;

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // register port
  assign cfg_pready   = 1'b1;
  assign cfg_idx      = rgmg_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_bound_wr = cfg_wr && (cfg_idx == rgmg_pkg::REG_MIN_X ||
                                   cfg_idx == rgmg_pkg::REG_MIN_Y ||
                                   cfg_idx == rgmg_pkg::REG_MAX_X ||
                                   cfg_idx == rgmg_pkg::REG_MAX_Y ||
                                   cfg_idx == rgmg_pkg::REG_EDGE_MARGIN);

  always_comb begin
    case (cfg_idx)
      rgmg_pkg::REG_MIN_X:       cfg_prdata = {8'd0, min_x_r};
      rgmg_pkg::REG_MIN_Y:       cfg_prdata = {8'd0, min_y_r};
      rgmg_pkg::REG_MAX_X:       cfg_prdata = {8'd0, max_x_r};
      rgmg_pkg::REG_MAX_Y:       cfg_prdata = {8'd0, max_y_r};
      rgmg_pkg::REG_EDGE_MARGIN: cfg_prdata = {9'd0, margin_r};
      rgmg_pkg::REG_TIMEOUT:     cfg_prdata = timeout_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r   <= '0;
      min_y_r   <= '0;
      max_x_r   <= '0;
      max_y_r   <= '0;
      margin_r  <= '0;
      timeout_r <= rgmg_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgmg_pkg::REG_MIN_X:       min_x_r   <= cfg_pwdata[CW-1:0];
        rgmg_pkg::REG_MIN_Y:       min_y_r   <= cfg_pwdata[CW-1:0];
        rgmg_pkg::REG_MAX_X:       max_x_r   <= cfg_pwdata[CW-1:0];
        rgmg_pkg::REG_MAX_Y:       max_y_r   <= cfg_pwdata[CW-1:0];
        rgmg_pkg::REG_EDGE_MARGIN: margin_r  <= cfg_pwdata[rgmg_pkg::MarginW-1:0];
        rgmg_pkg::REG_TIMEOUT:     timeout_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // evaluation, using the position as it stands after this transaction
  always_comb begin
    eff_x     = s1_r.cmd ? s1_r.pos_x          : cur_x_r;
    eff_y     = s1_r.cmd ? s1_r.pos_y          : cur_y_r;
    head_raw  = s1_r.cmd ? s1_r.heading_tenths : cur_head_r;
    eff_stamp = s1_r.cmd ? s1_r.now_ms         : stamp_r;
    eff_pv    = s1_r.cmd || pos_valid_r;

    head = (head_raw >= rgmg_pkg::HEADING_FULL) ? head_raw - rgmg_pkg::HEADING_FULL
                                                : head_raw;
    c_dxp = (head < rgmg_pkg::HEADING_90) || (head > rgmg_pkg::HEADING_270);
    c_dxn = (head > rgmg_pkg::HEADING_90) && (head < rgmg_pkg::HEADING_270);
    c_dyp = (head > rgmg_pkg::HEADING_0)  && (head < rgmg_pkg::HEADING_180);
    c_dyn = (head > rgmg_pkg::HEADING_180);
    if (s1_r.motion == rgmg_pkg::MOT_BACKWARD) begin
      dxp = c_dxn; dxn = c_dxp; dyp = c_dyn; dyn = c_dyp;
    end else begin
      dxp = c_dxp; dxn = c_dxn; dyp = c_dyp; dyn = c_dyn;
    end

    en    = (max_x_r > min_x_r) && (max_y_r > min_y_r);
    age   = s1_r.now_ms - eff_stamp;
    fresh = eff_pv && (age <= timeout_r);

    x_e  = EW'(eff_x);
    y_e  = EW'(eff_y);
    lo_x = EW'(min_x_r) + EW'(margin_r);
    hi_x = EW'(max_x_r) - EW'(margin_r);
    lo_y = EW'(min_y_r) + EW'(margin_r);
    hi_y = EW'(max_y_r) - EW'(margin_r);

    x_lo  = eff_x < min_x_r;
    x_hi  = eff_x > max_x_r;
    y_lo  = eff_y < min_y_r;
    y_hi  = eff_y > max_y_r;
    outside = x_lo || x_hi || y_lo || y_hi;
    n_xlo = x_e <= lo_x;
    n_xhi = x_e >= hi_x;
    n_ylo = y_e <= lo_y;
    n_yhi = y_e >= hi_y;
    near  = n_xlo || n_xhi || n_ylo || n_yhi;

    if (outside) begin
      dir_ok = !((x_lo && !dxp) || (x_hi && !dxn) || (y_lo && !dyp) || (y_hi && !dyn));
    end else begin
      dir_ok = !((n_xlo && dxn) || (n_xhi && dxp) || (n_ylo && dyn) || (n_yhi && dyp));
    end

    res_nxt.emergency_stop = en && !fresh;
    if (!en) begin
      res_nxt.motion_allowed = 1'b1;
    end else begin
      case (s1_r.motion)
        rgmg_pkg::MOT_STOP:     res_nxt.motion_allowed = 1'b1;
        rgmg_pkg::MOT_LEFT,
        rgmg_pkg::MOT_RIGHT:    res_nxt.motion_allowed = fresh;
        rgmg_pkg::MOT_FORWARD,
        rgmg_pkg::MOT_BACKWARD: res_nxt.motion_allowed = fresh && dir_ok;
        default:                res_nxt.motion_allowed = 1'b0;
      endcase
    end

    if (!en)              res_nxt.zone_status = rgmg_pkg::ZONE_DISABLED;
    else if (!eff_pv)     res_nxt.zone_status = rgmg_pkg::ZONE_UNKNOWN;
    else if (!fresh)      res_nxt.zone_status = rgmg_pkg::ZONE_STALE;
    else if (outside)     res_nxt.zone_status = rgmg_pkg::ZONE_OUTSIDE;
    else if (near)        res_nxt.zone_status = rgmg_pkg::ZONE_NEAR;
    else                  res_nxt.zone_status = rgmg_pkg::ZONE_SAFE;
  end

  // pipeline control and stored position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_head_r  <= '0;
      stamp_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv && s1_r.cmd) begin
        cur_x_r     <= s1_r.pos_x;
        cur_y_r     <= s1_r.pos_y;
        cur_head_r  <= s1_r.heading_tenths;
        stamp_r     <= s1_r.now_ms;
      end
      if (cfg_bound_wr) begin
        pos_valid_r <= 1'b0;
      end else if (s1_adv && s1_r.cmd) begin
        pos_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

`ifndef SYNTH
  a_bound_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_bound_wr |=> !pos_valid_r)
    else $error("bound write did not clear position valid");

  a_update_stores: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.cmd && !cfg_bound_wr) |=>
      (pos_valid_r && stamp_r == $past(s1_r.now_ms)))
    else $error("position update not stored");

  a_estop_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.emergency_stop) |->
      (out_data.zone_status == rgmg_pkg::ZONE_UNKNOWN ||
       out_data.zone_status == rgmg_pkg::ZONE_STALE))
    else $error("emergency stop with fresh zone status");

  a_disabled_allows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zone_status == rgmg_pkg::ZONE_DISABLED) |->
      (out_data.motion_allowed && !out_data.emergency_stop))
    else $error("disabled rectangle blocked motion");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register lost a transaction");
`endif

endmodule

`default_nettype wire

>>> sim/rectangular_geofence_motion_gate_test.sv
// Testbench for rectangular_geofence_motion_gate: directed and random position/motion
// transactions under several bound settings and handshake throttling, checked against a
// cycle-free verdict predictor. Depends on rgmg_pkg and the gate RTL.
`timescale 1ns / 1ps

module rectangular_geofence_motion_gate_test;
  import rgmg_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int BOX_X = 1000 * 256;
  localparam int BOX_Y = 500 * 256;
  localparam int BAND = 50 * 256;
  localparam logic [31:0] T0 = 32'h0001_0000;
  localparam logic [2:0] MOT_BAD_LO = 3'd5;
  localparam logic [2:0] MOT_BAD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [DataW-1:0] cfg_pwdata = '0;
  logic [DataW-1:0] cfg_prdata;
  logic cfg_pready;

  rectangular_geofence_motion_gate u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gate configuration and stored position as the predictor sees them
  logic signed [23:0] lim_min_x = '0, lim_min_y = '0, lim_max_x = '0, lim_max_y = '0;
  logic [22:0] band_q = '0;
  logic [31:0] timeout_ms = TIMEOUT_RESET;
  logic signed [23:0] cur_x = '0, cur_y = '0;
  logic [11:0] cur_heading = '0;
  logic [31:0] stamp_ms = '0;
  logic pos_valid = 1'b0;

  in_item_t pending_moves[$];
  out_item_t expected_verdicts[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  bit in_accepted = 1'b0;
  logic [31:0] clock_ms, seq_stamp;

  function automatic out_item_t evaluate_gate(in_item_t it);
    out_item_t r;
    logic [11:0] h;
    logic [2:0] mot;
    logic [31:0] age;
    longint x, y, lx, ly, hx, hy, m;
    int dx, dy;
    bit enabled, fresh, outside, near, ok;
    if (it.cmd) begin
      cur_x = it.pos_x;
      cur_y = it.pos_y;
      cur_heading = it.heading_tenths;
      stamp_ms = it.now_ms;
      pos_valid = 1'b1;
    end
    mot = it.motion;
    x = longint'(cur_x);
    y = longint'(cur_y);
    lx = longint'(lim_min_x);
    ly = longint'(lim_min_y);
    hx = longint'(lim_max_x);
    hy = longint'(lim_max_y);
    m = longint'(band_q);
    age = it.now_ms - stamp_ms;
    enabled = (hx > lx) && (hy > ly);
    fresh = pos_valid && (age <= timeout_ms);
    outside = x < lx || x > hx || y < ly || y > hy;
    near = x <= lx + m || x >= hx - m || y <= ly + m || y >= hy - m;

    h = cur_heading;
    if (h >= HEADING_FULL) h = h - HEADING_FULL;
    if (h == HEADING_90 || h == HEADING_270) dx = 0;
    else if (h < HEADING_90 || h > HEADING_270) dx = 1;
    else dx = -1;
    if (h == HEADING_0 || h == HEADING_180) dy = 0;
    else if (h < HEADING_180) dy = 1;
    else dy = -1;
    if (mot == MOT_BACKWARD) begin
      dx = -dx;
      dy = -dy;
    end

    if (!enabled || mot == MOT_STOP) ok = 1'b1;
    else if (mot > MOT_RIGHT) ok = 1'b0;
    else if (!fresh) ok = 1'b0;
    else if (mot == MOT_LEFT || mot == MOT_RIGHT) ok = 1'b1;
    else if (outside)
      ok = !((x < lx && dx <= 0) || (x > hx && dx >= 0) ||
             (y < ly && dy <= 0) || (y > hy && dy >= 0));
    else
      ok = !((x <= lx + m && dx < 0) || (x >= hx - m && dx > 0) ||
             (y <= ly + m && dy < 0) || (y >= hy - m && dy > 0));

    r.motion_allowed = ok;
    r.emergency_stop = enabled && !fresh;
    if (!enabled) r.zone_status = ZONE_DISABLED;
    else if (!pos_valid) r.zone_status = ZONE_UNKNOWN;
    else if (!fresh) r.zone_status = ZONE_STALE;
    else if (outside) r.zone_status = ZONE_OUTSIDE;
    else if (near) r.zone_status = ZONE_NEAR;
    else r.zone_status = ZONE_SAFE;
    return r;
  endfunction

  // driver: feeds pending transactions, throttles both sides
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_accepted) begin
        if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_moves.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predicts on input accept, checks on result accept, watchdog
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_accepted = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $error("result transaction with no expectation pending");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.motion_allowed !== want.motion_allowed) begin
            errors++;
            $error("motion_allowed: expected %0d, got %0d",
                   want.motion_allowed, out_data.motion_allowed);
          end
          if (out_data.emergency_stop !== want.emergency_stop) begin
            errors++;
            $error("emergency_stop: expected %0d, got %0d",
                   want.emergency_stop, out_data.emergency_stop);
          end
          if (out_data.zone_status !== want.zone_status) begin
            errors++;
            $error("zone_status: expected %0d, got %0d",
                   want.zone_status, out_data.zone_status);
          end
        end
      end
      if (in_accepted) expected_verdicts.push_back(evaluate_gate(in_data));
      if (in_accepted || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_MIN_X: lim_min_x = val[23:0];
      REG_MIN_Y: lim_min_y = val[23:0];
      REG_MAX_X: lim_max_x = val[23:0];
      REG_MAX_Y: lim_max_y = val[23:0];
      REG_EDGE_MARGIN: band_q = val[22:0];
      REG_TIMEOUT: timeout_ms = val;
      default: ;
    endcase
    if (idx != REG_TIMEOUT) pos_valid = 1'b0;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_bounds(int lx, int ly, int hx, int hy, int m, logic [31:0] tmo);
    cfg_write(REG_MIN_X, lx);
    cfg_write(REG_MIN_Y, ly);
    cfg_write(REG_MAX_X, hx);
    cfg_write(REG_MAX_Y, hy);
    cfg_write(REG_EDGE_MARGIN, m);
    cfg_write(REG_TIMEOUT, tmo);
  endtask

  task automatic settle();
    while (pending_moves.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic cmd, logic [23:0] x, logic [23:0] y,
                                         logic [11:0] h, logic [2:0] mot, logic [31:0] t);
    in_item_t it;
    it.cmd = cmd;
    it.pos_x = x;
    it.pos_y = y;
    it.heading_tenths = h;
    it.motion = mot;
    it.now_ms = t;
    return it;
  endfunction

  function automatic logic [23:0] pick_coord(logic signed [23:0] lo, logic signed [23:0] hi);
    longint v, a, b, span;
    a = longint'(lo);
    b = longint'(hi);
    span = b - a;
    case ($urandom_range(7))
      0: v = (span > 0) ? a + longint'($urandom) % (span + 1) : a;
      1: v = a + longint'(band_q) + longint'($urandom_range(0, 4)) - 2;
      2: v = b - longint'(band_q) + longint'($urandom_range(0, 4)) - 2;
      3: v = a + longint'($urandom_range(0, 4)) - 2;
      4: v = b + longint'($urandom_range(0, 4)) - 2;
      5: v = a - 1 - longint'($urandom_range(0, 1000));
      6: v = b + 1 + longint'($urandom_range(0, 1000));
      default: v = longint'($urandom_range(0, 24'hFFFFFF)) - 8388608;
    endcase
    if (v < -8388608) v = -8388608;
    if (v > 8388607) v = 8388607;
    return v[23:0];
  endfunction

  function automatic logic [11:0] pick_heading();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return HEADING_90 * 12'($urandom_range(0, 3)) + 12'($urandom_range(0, 2)) - 12'd1;
    if (sel < 9) return 12'($urandom_range(0, 3599));
    return 12'($urandom_range(3600, 4095));
  endfunction

  function automatic logic [2:0] pick_motion();
    int p;
    p = $urandom_range(99);
    if (p < 35) return MOT_FORWARD;
    if (p < 70) return MOT_BACKWARD;
    if (p < 78) return MOT_STOP;
    if (p < 86) return MOT_LEFT;
    if (p < 94) return MOT_RIGHT;
    return 3'($urandom_range(MOT_BAD_LO, MOT_BAD_HI));
  endfunction

  function automatic logic [31:0] pick_age();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return timeout_ms;
      2: return timeout_ms + 32'd1;
      3: return timeout_ms - 32'd1;
      4: return 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  // position update followed by a few queries, with some noise in between
  task automatic add_sequences(int n);
    int made;
    int k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 12) begin
        pending_moves.push_back(make_item(1'($urandom), 24'($urandom), 24'($urandom),
                                          12'($urandom), 3'($urandom), $urandom));
        made++;
      end else begin
        seq_stamp = clock_ms;
        pending_moves.push_back(make_item(1'b1, pick_coord(lim_min_x, lim_max_x),
                                          pick_coord(lim_min_y, lim_max_y), pick_heading(),
                                          pick_motion(), seq_stamp));
        made++;
        k = $urandom_range(1, 5);
        repeat (k) begin
          pending_moves.push_back(make_item(1'b0, 24'($urandom), 24'($urandom),
                                            12'($urandom), pick_motion(),
                                            seq_stamp + pick_age()));
          made++;
        end
        clock_ms = clock_ms + (($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2000));
      end
    end
  endtask

  task automatic add_directed();
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_STOP, T0));
    pending_moves.push_back(make_item(1'b1, '0, '0, HEADING_0, MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b0, 24'h7FFFFF, 24'h800000, 12'hFFF, MOT_BACKWARD,
                                      T0 + 32'd500));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_FORWARD, T0 + 32'd501));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_LEFT, T0 + 32'd501));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_STOP, T0 + 32'd501));
    pending_moves.push_back(make_item(1'b1, 24'(-BOX_X + BAND), '0, HEADING_180,
                                      MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_BACKWARD, T0));
    pending_moves.push_back(make_item(1'b1, 24'(BOX_X - BAND), 24'(BOX_Y - BAND), 12'd450,
                                      MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b1, 24'(-BOX_X - 256), '0, HEADING_0,
                                      MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b1, 24'(-BOX_X - 256), '0, HEADING_90,
                                      MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b1, 24'(BOX_X + 256), 24'(BOX_Y + 256), 12'd2250,
                                      MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_BACKWARD, T0));
    pending_moves.push_back(make_item(1'b1, '0, '0, HEADING_FULL, MOT_BACKWARD, T0));
    pending_moves.push_back(make_item(1'b1, '0, 24'(-BOX_Y + BAND), 12'hFFF,
                                      MOT_FORWARD, T0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_RIGHT, T0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_BAD_LO, T0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_BAD_HI, T0));
    pending_moves.push_back(make_item(1'b1, 24'h800000, 24'h7FFFFF, 12'd1799,
                                      MOT_FORWARD, 32'hFFFF_FFFF));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_BACKWARD, 32'h0));
    pending_moves.push_back(make_item(1'b0, '0, '0, HEADING_0, MOT_FORWARD, 32'hFFFF_FFFE));
  endtask

  initial begin : stimulus
    int k;
    clock_ms = $urandom;
    seq_stamp = clock_ms;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: rectangle disabled
    add_sequences(80);
    settle();

    set_bounds(-BOX_X, -BOX_Y, BOX_X, BOX_Y, BAND, 32'd500);
    add_directed();
    settle();
    send_idle_pct = 51;
    add_sequences(400);
    settle();

    set_bounds(-8388608, -8388608, 8388607, 8388607, 8388607, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    add_sequences(320);
    settle();

    set_bounds(0, -1, 1, 0, 0, 32'd0);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    add_sequences(320);
    settle();

    // zero-width rectangle stays disabled
    set_bounds(100, -50, 100, 5000, 10, 32'd1000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_sequences(150);
    settle();

    set_bounds(-int'($urandom_range(256, 400000)), -int'($urandom_range(256, 400000)),
               int'($urandom_range(256, 400000)), int'($urandom_range(256, 400000)),
               int'($urandom_range(0, 20000)), 32'($urandom_range(1, 5000)));
    send_idle_pct = 34;
    recv_stall_pct = 34;
    add_sequences(330);
    settle();

    // timeout-only write keeps the stored position valid
    cfg_write(REG_TIMEOUT, 32'd3000);
    send_idle_pct = 51;
    recv_stall_pct = 0;
    for (k = 0; k < 4; k++)
      pending_moves.push_back(make_item(1'b0, 24'($urandom), 24'($urandom), 12'($urandom),
                                        pick_motion(), seq_stamp + pick_age()));
    add_sequences(150);
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 51;
    add_sequences(150);
    settle();

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rgmg_pkg.sv
rtl/core/rectangular_geofence_motion_gate.sv
sim/rectangular_geofence_motion_gate_test.sv
